// ----- sv/crc_pkg.sv -----
// ----------------------------------------------------------------------------
// crc_pkg - circle raster canvas shared definitions
// command codes, register indexes, shape codes and the structs passed
// between the canvas modules
// ----------------------------------------------------------------------------
package crc_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_DRAW  = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_BG     = 2'd2;

  localparam logic [8:0] WIDTH_RST  = 9'd256;
  localparam logic [8:0] HEIGHT_RST = 9'd256;
  localparam logic [7:0] BG_RST     = 8'd32;

  localparam logic [7:0] SHAPE_RING = 8'd99;
  localparam logic [7:0] SHAPE_FILL = 8'd67;

  localparam logic [17:0] ONE_Q8 = 18'd256;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] bg;
  } cfg_t;

  typedef struct packed {
    logic               fill;
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic        [17:0] r;
    logic        [7:0]  ink;
  } circle_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

endpackage

// ----- sv/circle_raster_canvas.sv -----
// ----------------------------------------------------------------------------
// circle_raster_canvas - byte canvas with circle rasterizer
// clear / draw circle / read pixel commands on a canvas held in one ram
// ----------------------------------------------------------------------------
// clear does one pixel write per cycle
// draw tests one pixel per cycle in a
// three stage distance pipeline feeding the ram write port
// read and invalid or unused commands skip the scan (an in-range read does one ram read)
// one command is worked on at a time; the result register frees the input
// reset clears control and sets the config registers to their defaults; the canvas is undefined until a clear
module circle_raster_canvas #(
  parameter int MAX_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // shape_char, center_x, center_y, circle_radius,
                                  // ink_char, read_col, read_row
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, pixel_char
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import crc_pkg::*;

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 2 * SIDE_W;

  cfg_t              cfg;
  state_t            state_r, state_nxt;
  circle_t           circ_r, circ_nxt;
  logic              clear_r, clear_nxt;
  logic              status_r, status_nxt;
  logic              use_rd_r, use_rd_nxt;
  logic [SIDE_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [7:0]        out_pix_r, out_pix_nxt;

  logic              accept;
  cmd_t              cmd;
  logic [7:0]        shape, rd_col, rd_row;
  logic              shape_ok, draw_ok, rd_ok;
  logic [CNT_W-1:0]  w_eff, h_eff;
  logic [10:0]       w11, h11;
  logic              last_col, last_row;
  logic              scanning, issue, dist_busy, out_free;
  logic              dist_we, ram_we, ram_re;
  logic [ADDR_W-1:0] dist_addr, ram_waddr, ram_raddr;
  logic [7:0]        dist_data, ram_wdata, ram_rdata;

  crc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // active size, clamped to 1..MAX_SIDE
  always_comb begin
    w11 = {2'd0, cfg.width};
    h11 = {2'd0, cfg.height};
    if (w11 == 11'd0) begin
      w11 = 11'd1;
    end else if (w11 > 11'(MAX_SIDE)) begin
      w11 = 11'(MAX_SIDE);
    end
    if (h11 == 11'd0) begin
      h11 = 11'd1;
    end else if (h11 > 11'(MAX_SIDE)) begin
      h11 = 11'(MAX_SIDE);
    end
  end

  assign w_eff = CNT_W'(w11);
  assign h_eff = CNT_W'(h11);

  // request decode
  assign cmd      = in_tuser;
  assign shape    = in_tdata[7:0];
  assign rd_col   = in_tdata[79:72];
  assign rd_row   = in_tdata[87:80];
  assign shape_ok = (shape == SHAPE_RING) || (shape == SHAPE_FILL);
  assign draw_ok  = shape_ok && (in_tdata[63:46] != 18'd0);
  assign rd_ok    = ({3'd0, rd_col} < w11) && ({3'd0, rd_row} < h11);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  assign scanning = (state_r == ST_SCAN);
  assign issue    = scanning & ~clear_r;
  assign last_col = (col_r == SIDE_W'(w_eff - CNT_W'(1)));
  assign last_row = (row_r == SIDE_W'(h_eff - CNT_W'(1)));
  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt      = state_r;
    circ_nxt       = circ_r;
    clear_nxt      = clear_r;
    status_nxt     = status_r;
    use_rd_nxt     = use_rd_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_pix_nxt    = out_pix_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          circ_nxt.fill = (shape == SHAPE_FILL);
          circ_nxt.cx   = $signed(in_tdata[26:8]);
          circ_nxt.cy   = $signed(in_tdata[45:27]);
          circ_nxt.r    = in_tdata[63:46];
          circ_nxt.ink  = in_tdata[71:64];
          status_nxt    = 1'b0;
          use_rd_nxt    = 1'b0;
          col_nxt       = '0;
          row_nxt       = '0;
          case (cmd)
            CMD_CLEAR: begin
              clear_nxt = 1'b1;
              state_nxt = ST_SCAN;
            end
            CMD_DRAW: begin
              clear_nxt = 1'b0;
              if (draw_ok) begin
                state_nxt = ST_SCAN;
              end else begin
                status_nxt = 1'b1;
                state_nxt  = ST_FIN;
              end
            end
            CMD_READ: begin
              use_rd_nxt = rd_ok;
              state_nxt  = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + SIDE_W'(1);
          if (last_row) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pix_nxt    = use_rd_r ? ram_rdata : 8'd0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clear_r     <= 1'b0;
      status_r    <= 1'b0;
      use_rd_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clear_r     <= clear_nxt;
      status_r    <= status_nxt;
      use_rd_r    <= use_rd_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    circ_r       <= circ_nxt;
    out_status_r <= out_status_nxt;
    out_pix_r    <= out_pix_nxt;
  end

  crc_dist #(
    .SIDE_W (SIDE_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .circ    (circ_r),
    .issue   (issue),
    .col     (col_r),
    .row     (row_r),
    .busy    (dist_busy),
    .wr_en   (dist_we),
    .wr_addr (dist_addr),
    .wr_data (dist_data)
  );

  // canvas write port: clear sweep or covered pixels from the pipeline
  assign ram_we    = (scanning & clear_r) | dist_we;
  assign ram_waddr = clear_r ? {row_r, col_r} : dist_addr;
  assign ram_wdata = clear_r ? cfg.bg : dist_data;
  assign ram_re    = accept & (cmd == CMD_READ) & rd_ok;
  assign ram_raddr = {SIDE_W'(rd_row), SIDE_W'(rd_col)};

  crc_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_W)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_pix_r, out_status_r};

endmodule

// ----- sv/crc_ram.sv -----
// ----------------------------------------------------------------------------
// crc_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module crc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/crc_cfg.sv -----
// ----------------------------------------------------------------------------
// crc_cfg - configuration registers
// apb-style register file for canvas size and background byte
// ----------------------------------------------------------------------------
module crc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output crc_pkg::cfg_t cfg
);
  import crc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign idx   = cfg_paddr[3:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  cfg_nxt.width  = cfg_pwdata[8:0];
        REG_HEIGHT: cfg_nxt.height = cfg_pwdata[8:0];
        REG_BG:     cfg_nxt.bg     = cfg_pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.bg     <= BG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  cfg_prdata = {23'd0, cfg_r.width};
      REG_HEIGHT: cfg_prdata = {23'd0, cfg_r.height};
      REG_BG:     cfg_prdata = {24'd0, cfg_r.bg};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

endmodule

// ----- sv/crc_dist.sv -----
// ----------------------------------------------------------------------------
// crc_dist - pixel distance test pipeline
// squares the pixel offsets, compares against the radius bounds and
// issues a canvas write for every covered pixel
// ----------------------------------------------------------------------------
module crc_dist #(
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crc_pkg::circle_t      circ,
  input  logic                  issue,
  input  logic [SIDE_W-1:0]     col,
  input  logic [SIDE_W-1:0]     row,
  output logic                  busy,
  output logic                  wr_en,
  output logic [2*SIDE_W-1:0]   wr_addr,
  output logic [7:0]            wr_data
);
  import crc_pkg::*;

  localparam int D_W  = ((SIDE_W + 8 > 18) ? SIDE_W + 8 : 18) + 2;
  localparam int SQ_W = 2 * D_W;
  localparam int D2_W = SQ_W + 1;

  logic signed [D_W-1:0]  dx_nxt, dy_nxt;
  logic signed [D_W-1:0]  p1_dx_r, p1_dy_r;
  logic [2*SIDE_W-1:0]    p1_addr_r, p2_addr_r;
  logic                   p1_valid_r, p2_valid_r;
  logic signed [SQ_W-1:0] sq_x, sq_y;
  logic [SQ_W-1:0]        p2_dx2_r, p2_dy2_r;
  logic [35:0]            r2_r, rm2_r;
  logic [35:0]            r2_nxt, rm2_nxt;
  logic [17:0]            rm;
  logic                   rm_neg_r;
  logic [D2_W-1:0]        d2, r2_ext, rm2_ext;
  logic                   hit;

  // radius bounds, stable for the whole draw
  assign rm      = circ.r - ONE_Q8;
  assign r2_nxt  = 36'(circ.r) * 36'(circ.r);
  assign rm2_nxt = 36'(rm) * 36'(rm);

  always_ff @(posedge clk) begin
    r2_r     <= r2_nxt;
    rm2_r    <= rm2_nxt;
    rm_neg_r <= (circ.r[17:8] == 10'd0);
  end

  // stage 1: offsets from the center
  assign dx_nxt = $signed({{(D_W-SIDE_W-8){1'b0}}, col, 8'd0})
                - $signed({{(D_W-19){circ.cx[18]}}, circ.cx});
  assign dy_nxt = $signed({{(D_W-SIDE_W-8){1'b0}}, row, 8'd0})
                - $signed({{(D_W-19){circ.cy[18]}}, circ.cy});

  always_ff @(posedge clk) begin
    p1_dx_r   <= dx_nxt;
    p1_dy_r   <= dy_nxt;
    p1_addr_r <= {row, col};
  end

  // stage 2: squares
  assign sq_x = p1_dx_r * p1_dx_r;
  assign sq_y = p1_dy_r * p1_dy_r;

  always_ff @(posedge clk) begin
    p2_dx2_r  <= sq_x;
    p2_dy2_r  <= sq_y;
    p2_addr_r <= p1_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= issue;
      p2_valid_r <= p1_valid_r;
    end
  end

  // stage 3: compare and write
  assign d2      = D2_W'(p2_dx2_r) + D2_W'(p2_dy2_r);
  assign r2_ext  = D2_W'(r2_r);
  assign rm2_ext = D2_W'(rm2_r);

  always_comb begin
    if (circ.fill) begin
      hit = (d2 <= r2_ext);
    end else begin
      hit = (d2 < r2_ext) && (rm_neg_r || (d2 > rm2_ext));
    end
  end

  assign busy    = p1_valid_r | p2_valid_r;
  assign wr_en   = p2_valid_r & hit;
  assign wr_addr = p2_addr_r;
  assign wr_data = circ.ink;

endmodule

// ----- bench/circle_raster_canvas_tb.sv -----
// ----------------------------------------------------------------------------
// circle_raster_canvas_tb - self-checking bench for the circle raster canvas
// a short table of clear, draw, read and unused commands goes first (full
// size canvas after reset, then a small one), then random command streams
// run under several canvas sizes, four with random gaps on both streams;
// answers are compared to table values or a copy of the canvas and its registers
// ----------------------------------------------------------------------------
module circle_raster_canvas_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc_pkg::*;

  localparam int SIDE = 256;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 12;

  typedef struct packed {
    logic       status;
    logic [7:0] pix;
  } answer_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  shape;
    logic [18:0] cx;
    logic [18:0] cy;
    logic [17:0] r;
    logic [7:0]  ink;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        typed;
    logic        st;
    logic [7:0]  px;
  } script_row_t;

  // first twelve rows run on the reset size, the rest on a 10 x 10 canvas
  localparam script_row_t SCRIPT [24] = '{
    '{CMD_CLEAR, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd32},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, 8'd32},
    '{CMD_DRAW, SHAPE_FILL, 19'd32768, 19'd32768, 18'd2560, 8'h2A, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd128, 8'd128, 1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd138, 8'd128, 1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, 8'h78, 19'd512, 19'd512, 18'd512, 8'h41, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0},
    '{CMD_DRAW, SHAPE_FILL, 19'd512, 19'd512, 18'd0, 8'h41, 8'd0, 8'd0,
      1'b1, 1'b1, 8'd0},
    '{CMD_DRAW, SHAPE_RING, 19'd512, 19'd512, 18'd0, 8'h41, 8'd0, 8'd0,
      1'b1, 1'b1, 8'd0},
    '{CMD_DRAW, 8'h00, 19'h40000, 19'h3FFFF, 18'd512, 8'h00, 8'd0, 8'd0,
      1'b1, 1'b1, 8'd0},
    '{CMD_DRAW, 8'hFF, 19'h3FFFF, 19'h40000, 18'h3FFFF, 8'hFF, 8'd255, 8'd255,
      1'b1, 1'b1, 8'd0},
    '{CMD_NOP, 8'hFF, 19'h7FFFF, 19'h7FFFF, 18'h3FFFF, 8'hFF, 8'd255, 8'd255,
      1'b1, 1'b0, 8'd0},
    '{CMD_CLEAR, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, SHAPE_RING, 19'd1280, 19'd1280, 18'd256, 8'h58, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, SHAPE_RING, 19'd640, 19'd640, 18'd128, 8'h6F, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, SHAPE_RING, 19'd1280, 19'd1280, 18'd768, 8'h2B, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, SHAPE_FILL, 19'h40000, 19'h3FFFF, 18'h3FFFF, 8'h40, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_DRAW, SHAPE_FILL, 19'h3FFFF, 19'd0, 18'h3FFFF, 8'h23, 8'd0, 8'd0,
      1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd5, 8'd5, 1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd9, 8'd0, 1'b0, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd10, 8'd3, 1'b1, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd3, 8'd10, 1'b1, 1'b0, 8'd0},
    '{CMD_READ, 8'd0, 19'd0, 19'd0, 18'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0}
  };

  // width, height, background per random phase
  localparam logic [31:0] PHASE_CFG [PHASES][3] = '{
    '{32'd12, 32'd10, 32'd46},
    '{32'd0, 32'd0, 32'd0},
    '{32'd511, 32'd1, 32'd255},
    '{32'd1, 32'd300, 32'd97},
    '{32'd16, 32'd16, 32'd35},
    '{32'd7, 32'd5, 32'd126}
  };

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = CMD_NOP;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit   [7:0]  pixels [SIDE*SIDE];
  logic [8:0]  width_reg  = WIDTH_RST;
  logic [8:0]  height_reg = HEIGHT_RST;
  logic [7:0]  bg_reg     = BG_RST;
  answer_t     answers_due [$];
  int          mismatches = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;

  circle_raster_canvas i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("circle_raster_canvas_tb: FAIL");
    $finish;
  end

  function automatic int active_side(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  function automatic logic [87:0] pack_request(logic [7:0] shape, logic [18:0] cx,
                                               logic [18:0] cy, logic [17:0] r,
                                               logic [7:0] ink, logic [7:0] col,
                                               logic [7:0] row);
    return {row, col, ink, r, cy, cx, shape};
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // answer of the canvas to one request, applying its side effects
  task automatic canvas_answer(input cmd_t cmd, input logic [87:0] data,
                               output answer_t ans);
    int         w, h, col, row;
    logic [7:0] shape;
    longint     cx, cy, r, rm, r2, rm2, dx, dy, d2;
    bit         hit;
    w = active_side(width_reg);
    h = active_side(height_reg);
    ans = '0;
    case (cmd)
      CMD_CLEAR: begin
        for (row = 0; row < h; row++)
          for (col = 0; col < w; col++)
            pixels[row*SIDE + col] = bg_reg;
      end
      CMD_DRAW: begin
        shape = data[7:0];
        cx = $signed(data[26:8]);
        cy = $signed(data[45:27]);
        r  = longint'(data[63:46]);
        if ((shape != SHAPE_RING && shape != SHAPE_FILL) || r == 0) begin
          ans.status = 1'b1;
        end else begin
          r2  = r * r;
          rm  = r - longint'(ONE_Q8);
          rm2 = rm * rm;
          for (row = 0; row < h; row++) begin
            dy = longint'(row) * 256 - cy;
            for (col = 0; col < w; col++) begin
              dx = longint'(col) * 256 - cx;
              d2 = dx * dx + dy * dy;
              if (shape == SHAPE_FILL) hit = (d2 <= r2);
              else hit = (d2 < r2) && (rm < 0 || d2 > rm2);
              if (hit) pixels[row*SIDE + col] = data[71:64];
            end
          end
        end
      end
      CMD_READ: begin
        col = int'(data[79:72]);
        row = int'(data[87:80]);
        if (col < w && row < h) ans.pix = pixels[row*SIDE + col];
      end
      default: ;
    endcase
  endtask

  task automatic offer_request(cmd_t cmd, logic [87:0] data, bit typed, answer_t want);
    answer_t ans;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    canvas_answer(cmd, data, ans);
    answers_due.push_back(typed ? want : ans);
  endtask

  task automatic drain_requests();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    logic [31:0] held;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WIDTH:  width_reg  = value[8:0];
      REG_HEIGHT: height_reg = value[8:0];
      default:    bg_reg     = value[7:0];
    endcase
    held = (idx == REG_BG) ? {24'd0, value[7:0]} : {23'd0, value[8:0]};
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== held) flag_mismatch("register readback", cfg_prdata, held);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_canvas(logic [31:0] w, logic [31:0] h, logic [31:0] bg);
    drain_requests();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BG, bg);
  endtask

  task automatic random_request(output cmd_t cmd, output logic [87:0] data);
    int w, h, side, pick, px, py, frac;
    w = active_side(width_reg);
    h = active_side(height_reg);
    side = (w > h) ? w : h;
    data = 88'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 5) begin
      cmd = CMD_CLEAR;
    end else if (pick < 10) begin
      cmd = CMD_NOP;
    end else if (pick < 50) begin
      cmd = CMD_DRAW;
      pick = $urandom_range(99);
      if (pick < 45) data[7:0] = SHAPE_RING;
      else if (pick < 90) data[7:0] = SHAPE_FILL;
      // mostly circles near the canvas, sometimes raw noise in the geometry
      if ($urandom_range(19) != 0) begin
        frac = ($urandom_range(2) == 0) ? 0 : int'($urandom_range(255));
        px = int'($urandom_range(side + 6)) - 3;
        py = int'($urandom_range(side + 6)) - 3;
        data[26:8]  = 19'(px * 256 + frac);
        data[45:27] = 19'(py * 256 + (($urandom_range(1) == 0) ? 0 : frac));
        pick = $urandom_range(99);
        if (pick < 10) data[63:46] = '0;
        else if (pick < 25) data[63:46] = 18'($urandom_range(255));
        else if (pick < 60) data[63:46] = 18'($urandom_range(side) * 256);
        else data[63:46] = 18'($urandom_range((side + 2) * 256));
      end
    end else begin
      cmd = CMD_READ;
      if ($urandom_range(99) < 85) begin
        data[79:72] = 8'($urandom_range(w - 1));
        data[87:80] = 8'($urandom_range(h - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("result with nothing pending", {16'd0, out_tdata}, 32'd0);
      end else begin
        want = answers_due.pop_front();
        if (out_tdata[0] !== want.status)
          flag_mismatch("status", {31'd0, out_tdata[0]}, {31'd0, want.status});
        if (out_tdata[8:1] !== want.pix)
          flag_mismatch("pixel_char", {24'd0, out_tdata[8:1]}, {24'd0, want.pix});
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cmd_t        cmd;
    logic [87:0] data;
    script_row_t step;
    idle_pct  = 36;
    stall_pct = 63;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++) begin
      step = SCRIPT[i];
      if (i == 12) set_canvas(32'd10, 32'd10, 32'd46);
      offer_request(step.cmd, pack_request(step.shape, step.cx, step.cy, step.r,
                                           step.ink, step.col, step.row),
                    step.typed, '{status: step.st, pix: step.px});
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        idle_pct  = 63;
        stall_pct = 36;
      end else if (p == 4) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      set_canvas(PHASE_CFG[p][0], PHASE_CFG[p][1], PHASE_CFG[p][2]);
      // every phase starts from a cleared canvas so no read hits unwritten pixels
      offer_request(CMD_CLEAR, 88'({$urandom, $urandom, $urandom}), 1'b0, '0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_request(cmd, data);
        offer_request(cmd, data, 1'b0, '0);
      end
    end

    drain_requests();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("circle_raster_canvas_tb: PASS");
    end else begin
      $display("circle_raster_canvas_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- circle_raster_canvas.f -----
sv/crc_pkg.sv
sv/crc_ram.sv
sv/crc_cfg.sv
sv/crc_dist.sv
sv/circle_raster_canvas.sv
bench/circle_raster_canvas_tb.sv
